### hdl/ptr_pkg.sv
// Shared types, widths and codes for the planar tensor rotation unit.
package ptr_pkg;

    // Widths
    localparam int DATA_W  = 32;   // payload word, Q16.16
    localparam int FRAC    = 16;   // fraction bits of the trig registers
    localparam int TRIG_W  = 18;   // trig register width
    localparam int ANG_W   = 19;   // trig value after optional negation
    localparam int POW1_W  = 20;   // cc, ss, sc
    localparam int POW2_W  = 22;   // c4, s4, s2c2, sc3, s3c
    localparam int COMB_W  = 36;   // pre-added data combinations
    localparam int PROD_W  = COMB_W + POW2_W;
    localparam int ACC_W   = 64;   // exact sums
    localparam int N_LANES = 18;   // multiplier lanes
    localparam int N_RES   = 6;    // result words
    localparam int N_REGS  = 6;
    localparam int IDX_W   = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COS_T  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIN_T  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COS_2T = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIN_2T = 3'd3;
    localparam logic [IDX_W-1:0] REG_COS_4T = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIN_4T = 3'd5;

    typedef enum logic [1:0] {
        ACT_STRESS = 2'd0,
        ACT_TENSOR = 2'd1,
        ACT_MATRIX = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Final rounding shift of one result word
    typedef enum logic [1:0] {
        RND_16 = 2'd0,
        RND_17 = 2'd1,
        RND_19 = 2'd2
    } t_rnd;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [COMB_W-1:0] t_combw;
    typedef logic signed [POW2_W-1:0] t_pw;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        t_action action;
        logic    rotate_out;
        logic    index_sel;
        t_word   in_a0;
        t_word   in_a1;
        t_word   in_a2;
        t_word   in_a3;
        t_word   in_a4;
        t_word   in_a5;
    } t_in_item;

    typedef struct packed {
        t_word out_b0;
        t_word out_b1;
        t_word out_b2;
        t_word out_b3;
        t_word out_b4;
        t_word out_b5;
        logic  saturated;
    } t_out_item;

    // Trig values with the rotation sign applied; sp is the unsigned-direction sine
    typedef struct packed {
        t_ang c;
        t_ang s;
        t_ang c2;
        t_ang s2;
        t_ang c4;
        t_ang s4;
        t_ang sp;
    } t_trig;

    typedef struct packed {
        t_combw p;
        t_combw d;
        t_combw xy2;
        t_combw s1122;
        t_combw d1122;
        t_combw s1323;
        t_combw d1323;
        t_combw mixin;
        t_combw ks4;
        t_combw k1;
        t_combw k5;
    } t_comb;

    typedef struct packed {
        t_pw c4;
        t_pw s4;
        t_pw s2c2;
        t_pw sc3;
        t_pw s3c;
    } t_pow;

    // Input register stage
    typedef struct packed {
        logic     valid;
        t_in_item item;
        t_trig    trig;
    } t_s0;

    // After trig powers
    typedef struct packed {
        logic     valid;
        t_in_item item;
        t_trig    trig;
        t_comb    comb;
        t_pow     pow;
    } t_s2;

    // Two addends and a rounding shift per result word
    typedef struct packed {
        logic                   valid;
        t_rnd [N_RES-1:0]       rsel;
        t_acc [N_RES-1:0]       x;
        t_acc [N_RES-1:0]       y;
    } t_s4;

endpackage

### hdl/ptr_trig.sv
// Trig power stages: cc/ss/sc and data pre-adds, then fourth-order trig powers.
module ptr_trig (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  ptr_pkg::t_s0 i_s0,
    output ptr_pkg::t_s2 o_s2
);
    import ptr_pkg::*;

    localparam int HALF = 1 << (FRAC - 1);

    // Stage 1 registers
    logic                     r1_valid;
    t_in_item                 r1_item;
    t_trig                    r1_trig;
    t_comb                    r1_comb;
    logic signed [POW1_W-1:0] r1_cc, r1_ss, r1_sc;

    logic signed [2*ANG_W-1:0]  w_cc, w_ss, w_sc;
    logic signed [2*POW1_W-1:0] w_c4, w_s4, w_s2c2, w_sc3, w_s3c;
    t_comb                      n_comb;
    t_combw                     a0, a1, a2, a3, a4, a5;

    // Second-order trig products
    assign w_cc = i_s0.trig.c * i_s0.trig.c;
    assign w_ss = i_s0.trig.s * i_s0.trig.s;
    assign w_sc = i_s0.trig.s * i_s0.trig.c;

    // Data pre-adds used by the stress and tensor actions
    always_comb begin
        a0 = COMB_W'(i_s0.item.in_a0);
        a1 = COMB_W'(i_s0.item.in_a1);
        a2 = COMB_W'(i_s0.item.in_a2);
        a3 = COMB_W'(i_s0.item.in_a3);
        a4 = COMB_W'(i_s0.item.in_a4);
        a5 = COMB_W'(i_s0.item.in_a5);
        n_comb.p     = a0 + a1;
        n_comb.d     = a0 - a1;
        n_comb.xy2   = a2 <<< 1;
        n_comb.s1122 = a0 + a3;
        n_comb.d1122 = a0 - a3;
        n_comb.s1323 = a2 + a4;
        n_comb.d1323 = a2 - a4;
        n_comb.mixin = (a1 <<< 1) + (a5 <<< 2);
        n_comb.ks4   = a0 + a3 - (a1 <<< 1) - (a5 <<< 2);
        n_comb.k1    = (a1 <<< 2) + (a1 <<< 1) - (a5 <<< 2);
        n_comb.k5    = (a5 <<< 2) - (a1 <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r1_item  <= i_s0.item;
        r1_trig  <= i_s0.trig;
        r1_comb  <= n_comb;
        r1_cc    <= POW1_W'((w_cc + HALF) >>> FRAC);
        r1_ss    <= POW1_W'((w_ss + HALF) >>> FRAC);
        r1_sc    <= POW1_W'((w_sc + HALF) >>> FRAC);
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_s0.valid;
        end
    end

    // Fourth-order trig products
    assign w_c4   = r1_cc * r1_cc;
    assign w_s4   = r1_ss * r1_ss;
    assign w_s2c2 = r1_ss * r1_cc;
    assign w_sc3  = r1_sc * r1_cc;
    assign w_s3c  = r1_sc * r1_ss;

    always_ff @(posedge i_clk) begin
        o_s2.item     <= r1_item;
        o_s2.trig     <= r1_trig;
        o_s2.comb     <= r1_comb;
        o_s2.pow.c4   <= POW2_W'((w_c4   + HALF) >>> FRAC);
        o_s2.pow.s4   <= POW2_W'((w_s4   + HALF) >>> FRAC);
        o_s2.pow.s2c2 <= POW2_W'((w_s2c2 + HALF) >>> FRAC);
        o_s2.pow.sc3  <= POW2_W'((w_sc3  + HALF) >>> FRAC);
        o_s2.pow.s3c  <= POW2_W'((w_s3c  + HALF) >>> FRAC);
        if (!i_rst_n) begin
            o_s2.valid <= 1'b0;
        end else begin
            o_s2.valid <= r1_valid;
        end
    end

endmodule

### hdl/ptr_mac.sv
// Multiplier lanes and first-level adds that reduce each result to two addends.
module ptr_mac (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  ptr_pkg::t_s2 i_s2,
    output ptr_pkg::t_s4 o_s4
);
    import ptr_pkg::*;

    t_combw                   opa [N_LANES];
    t_pw                      opb [N_LANES];
    t_combw                   n_sh0;
    logic signed [PROD_W-1:0] r3_prod [N_LANES];
    t_combw                   r3_sh0, r3_sh1, r3_sh2;
    t_action                  r3_action;
    logic                     r3_isel;
    logic                     r3_valid;

    t_acc             p [N_LANES];
    t_acc             sh0, sh1, sh2;
    t_acc [N_RES-1:0] n_x, n_y;
    t_rnd [N_RES-1:0] n_rsel;

    t_combw a0, a1, a2, a3, a4, a5;
    t_pw    tc, tsp, tc2, ts2, tc4, ts4;

    // Lane operand selection per action
    always_comb begin
        a0  = COMB_W'(i_s2.item.in_a0);
        a1  = COMB_W'(i_s2.item.in_a1);
        a2  = COMB_W'(i_s2.item.in_a2);
        a3  = COMB_W'(i_s2.item.in_a3);
        a4  = COMB_W'(i_s2.item.in_a4);
        a5  = COMB_W'(i_s2.item.in_a5);
        tc  = POW2_W'(i_s2.trig.c);
        tsp = POW2_W'(i_s2.trig.sp);
        tc2 = POW2_W'(i_s2.trig.c2);
        ts2 = POW2_W'(i_s2.trig.s2);
        tc4 = POW2_W'(i_s2.trig.c4);
        ts4 = POW2_W'(i_s2.trig.s4);
        for (int i = 0; i < N_LANES; i++) begin
            opa[i] = '0;
            opb[i] = '0;
        end
        n_sh0 = '0;
        case (i_s2.item.action)
            ACT_STRESS: begin
                n_sh0  = i_s2.comb.p;
                opa[0] = i_s2.comb.d;   opb[0] = tc2;
                opa[1] = i_s2.comb.xy2; opb[1] = ts2;
                opa[2] = i_s2.comb.xy2; opb[2] = tc2;
                opa[3] = i_s2.comb.d;   opb[3] = ts2;
            end
            ACT_TENSOR: begin
                n_sh0   = i_s2.comb.s1122;
                opa[0]  = a0;                opb[0]  = i_s2.pow.c4;
                opa[1]  = a3;                opb[1]  = i_s2.pow.s4;
                opa[2]  = i_s2.comb.mixin;   opb[2]  = i_s2.pow.s2c2;
                opa[3]  = a2;                opb[3]  = i_s2.pow.sc3;
                opa[4]  = a4;                opb[4]  = i_s2.pow.s3c;
                opa[5]  = a0;                opb[5]  = i_s2.pow.s4;
                opa[6]  = a3;                opb[6]  = i_s2.pow.c4;
                opa[7]  = a4;                opb[7]  = i_s2.pow.sc3;
                opa[8]  = a2;                opb[8]  = i_s2.pow.s3c;
                opa[9]  = i_s2.comb.s1122;   opb[9]  = tc4;
                opa[10] = a1;                opb[10] = tc4;
                opa[11] = a5;                opb[11] = tc4;
                opa[12] = i_s2.comb.d1323;   opb[12] = ts4;
                opa[13] = i_s2.comb.d1122;   opb[13] = ts2;
                opa[14] = i_s2.comb.s1323;   opb[14] = tc2;
                opa[15] = a4;                opb[15] = tc4;
                opa[16] = a2;                opb[16] = tc4;
                opa[17] = i_s2.comb.ks4;     opb[17] = ts4;
            end
            ACT_MATRIX: begin
                opa[0] = a0; opb[0] = tc;
                opa[1] = a1; opb[1] = tsp;
                opa[2] = a1; opb[2] = tc;
                opa[3] = a0; opb[3] = tsp;
                opa[4] = a2; opb[4] = tc;
                opa[5] = a3; opb[5] = tsp;
                opa[6] = a3; opb[6] = tc;
                opa[7] = a2; opb[7] = tsp;
            end
            default: begin
                n_sh0 = '0;
            end
        endcase
    end

    // Stage 3: products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_LANES; i++) begin
            r3_prod[i] <= opa[i] * opb[i];
        end
        r3_sh0    <= n_sh0;
        r3_sh1    <= i_s2.comb.k1;
        r3_sh2    <= i_s2.comb.k5;
        r3_action <= i_s2.item.action;
        r3_isel   <= i_s2.item.index_sel;
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= i_s2.valid;
        end
    end

    // Stage 4: reduce each result word to two addends
    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            p[i] = ACC_W'(r3_prod[i]);
        end
        sh0 = ACC_W'(r3_sh0) <<< FRAC;
        sh1 = ACC_W'(r3_sh1) <<< FRAC;
        sh2 = ACC_W'(r3_sh2) <<< FRAC;
        for (int i = 0; i < N_RES; i++) begin
            n_x[i]    = '0;
            n_y[i]    = '0;
            n_rsel[i] = RND_16;
        end
        case (r3_action)
            ACT_STRESS: begin
                n_x[0] = sh0 + p[0]; n_y[0] = p[1];
                n_x[1] = sh0 - p[0]; n_y[1] = -p[1];
                n_x[2] = p[2];       n_y[2] = -p[3];
                n_rsel[0] = RND_17;
                n_rsel[1] = RND_17;
                n_rsel[2] = RND_17;
            end
            ACT_TENSOR: begin
                n_x[0] = p[0] + p[1] + p[2];
                n_y[0] = -(p[3] <<< 2) - (p[4] <<< 2);
                n_x[3] = p[5] + p[6] + p[2];
                n_y[3] = (p[7] <<< 2) + (p[8] <<< 2);
                n_x[1] = sh1 + sh0 - p[9];
                n_y[1] = (p[10] <<< 1) + (p[11] <<< 2) + (p[12] <<< 2);
                n_x[5] = sh2 + sh0 - p[9];
                n_y[5] = (p[10] <<< 1) + (p[11] <<< 2) + (p[12] <<< 2);
                n_x[2] = (p[13] <<< 1) + (p[14] <<< 2);
                n_y[2] = (p[16] <<< 2) - (p[15] <<< 2) + p[17];
                n_x[4] = (p[13] <<< 1) + (p[14] <<< 2);
                n_y[4] = (p[15] <<< 2) - (p[16] <<< 2) - p[17];
                n_rsel[1] = RND_19;
                n_rsel[2] = RND_19;
                n_rsel[4] = RND_19;
                n_rsel[5] = RND_19;
            end
            ACT_MATRIX: begin
                if (r3_isel) begin
                    // M times Q
                    n_x[0] = p[0]; n_y[0] = p[1];
                    n_x[1] = p[2]; n_y[1] = -p[3];
                    n_x[2] = p[4]; n_y[2] = p[5];
                    n_x[3] = p[6]; n_y[3] = -p[7];
                end else begin
                    // Q transpose times M
                    n_x[0] = p[0]; n_y[0] = p[7];
                    n_x[1] = p[2]; n_y[1] = p[5];
                    n_x[2] = p[4]; n_y[2] = -p[3];
                    n_x[3] = p[6]; n_y[3] = -p[1];
                end
            end
            default: begin
                n_x[0] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_s4.x    <= n_x;
        o_s4.y    <= n_y;
        o_s4.rsel <= n_rsel;
        if (!i_rst_n) begin
            o_s4.valid <= 1'b0;
        end else begin
            o_s4.valid <= r3_valid;
        end
    end

endmodule

### hdl/ptr_sat.sv
// Final add, round half up and saturation into the output register.
module ptr_sat (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptr_pkg::t_s4       i_s4,
    output logic               o_done,
    output ptr_pkg::t_out_item o_result
);
    import ptr_pkg::*;

    localparam t_acc HALF16 = ACC_W'(1) <<< (FRAC - 1);
    localparam t_acc HALF17 = ACC_W'(1) <<< FRAC;
    localparam t_acc HALF19 = ACC_W'(1) <<< (FRAC + 2);

    t_acc      v   [N_RES];
    t_acc      rv  [N_RES];
    t_word     res [N_RES];
    logic      clip [N_RES];
    t_out_item n_result;

    // Per word: sum, round, clip to the payload width
    always_comb begin
        for (int i = 0; i < N_RES; i++) begin
            v[i] = $signed(i_s4.x[i]) + $signed(i_s4.y[i]);
            case (i_s4.rsel[i])
                RND_16:  rv[i] = (v[i] + HALF16) >>> FRAC;
                RND_17:  rv[i] = (v[i] + HALF17) >>> (FRAC + 1);
                RND_19:  rv[i] = (v[i] + HALF19) >>> (FRAC + 3);
                default: rv[i] = (v[i] + HALF16) >>> FRAC;
            endcase
            clip[i] = !((&rv[i][ACC_W-1:DATA_W-1]) || !(|rv[i][ACC_W-1:DATA_W-1]));
            if (clip[i]) begin
                res[i] = rv[i][ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                res[i] = rv[i][DATA_W-1:0];
            end
        end
        n_result.out_b0    = res[0];
        n_result.out_b1    = res[1];
        n_result.out_b2    = res[2];
        n_result.out_b3    = res[3];
        n_result.out_b4    = res[4];
        n_result.out_b5    = res[5];
        n_result.saturated = clip[0] | clip[1] | clip[2] | clip[3] | clip[4] | clip[5];
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_s4.valid;
        end
    end

endmodule

### hdl/planar_tensor_rotation_unit.sv
// Top level: configuration registers, input stage and the rotation pipeline.
//
// Rotates a Voigt stress, a reduced stiffness tensor or a 2x2 matrix by the
// angle held in six trig registers. One item is taken every clock cycle; its
// result appears on o_result with o_done high after the input register, the
// two trig-power stages, the multiplier lanes, the addend reduction and the
// round/saturate stage. Results must be taken in the cycle they are shown.
// busy is high only while reset is held. Write the trig registers only when
// no item is in flight.
module planar_tensor_rotation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ptr_pkg::t_in_item             i_item,
    output logic                          o_done,
    output ptr_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [ptr_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [ptr_pkg::TRIG_W-1:0]    i_cfg_data
);
    import ptr_pkg::*;

    logic signed [TRIG_W-1:0] r_cfg [N_REGS];
    t_s0                      n_s0;
    t_s0                      r_s0;
    t_s2                      w_s2;
    t_s4                      w_s4;

    assign busy = !i_rst_n;

    // Trig registers; reset gives the identity rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_COS_T]  <= TRIG_W'(1 << FRAC);
            r_cfg[REG_SIN_T]  <= '0;
            r_cfg[REG_COS_2T] <= TRIG_W'(1 << FRAC);
            r_cfg[REG_SIN_2T] <= '0;
            r_cfg[REG_COS_4T] <= TRIG_W'(1 << FRAC);
            r_cfg[REG_SIN_4T] <= '0;
        end else if (i_cfg_we && (i_cfg_idx < IDX_W'(N_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Input beat with rotation sign applied to the sines s, s2 and s4; sp keeps the stored sign
    always_comb begin
        n_s0.valid   = start && !busy;
        n_s0.item    = i_item;
        n_s0.trig.c  = ANG_W'(r_cfg[REG_COS_T]);
        n_s0.trig.c2 = ANG_W'(r_cfg[REG_COS_2T]);
        n_s0.trig.c4 = ANG_W'(r_cfg[REG_COS_4T]);
        n_s0.trig.sp = ANG_W'(r_cfg[REG_SIN_T]);
        if (i_item.rotate_out) begin
            n_s0.trig.s  = -ANG_W'(r_cfg[REG_SIN_T]);
            n_s0.trig.s2 = -ANG_W'(r_cfg[REG_SIN_2T]);
            n_s0.trig.s4 = -ANG_W'(r_cfg[REG_SIN_4T]);
        end else begin
            n_s0.trig.s  = ANG_W'(r_cfg[REG_SIN_T]);
            n_s0.trig.s2 = ANG_W'(r_cfg[REG_SIN_2T]);
            n_s0.trig.s4 = ANG_W'(r_cfg[REG_SIN_4T]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0.item <= n_s0.item;
        r_s0.trig <= n_s0.trig;
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else begin
            r_s0.valid <= n_s0.valid;
        end
    end

    ptr_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s0    (r_s0),
        .o_s2    (w_s2)
    );

    ptr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (w_s2),
        .o_s4    (w_s4)
    );

    ptr_sat u_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s4     (w_s4),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Every accepted beat comes out as a result with o_done high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##6 o_done)
        else $error("accepted beat produced no result");

    // No result without a matching accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 6))
        else $error("result without a matching beat");

    // Stress rotation leaves the upper words at zero
    a_stress_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(start && !busy && i_item.action == ACT_STRESS, 6)
        |-> o_result.out_b3 == '0 && o_result.out_b4 == '0 && o_result.out_b5 == '0)
        else $error("stress result has nonzero unused words");

    // Unused action code gives an all-zero result
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(start && !busy && i_item.action == ACT_NONE, 6)
        |-> o_result == '0)
        else $error("unused action gave nonzero result");

endmodule

### tb/sv/planar_tensor_rotation_unit_test.sv
// Self-checking testbench for the planar tensor rotation unit.
module planar_tensor_rotation_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ptr_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_done;
    t_out_item o_result;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [TRIG_W-1:0] i_cfg_data = '0;

    planar_tensor_rotation_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Angle registers as seen by the predictor
    logic signed [63:0] angle_reg [N_REGS];
    t_in_item  pending_items [$];
    t_out_item rotated_q [$];
    int mismatch_cnt = 0;
    int gap_left = 0;
    bit drive_en = 1'b0;

    function automatic logic signed [63:0] rnd_shift(logic signed [63:0] x, int n);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic t_word sat_word(logic signed [63:0] v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return t_word'(v);
    endfunction

    // Rotation of one beat at the current angle
    function automatic t_out_item rotate_item(t_in_item it);
        logic signed [63:0] a [6];
        logic signed [63:0] r [6];
        logic signed [63:0] c, s, c2, s2, c4t, s4t, sp, one;
        logic signed [63:0] p, d, cc, ss, sc, c4, s4, s2c2, sc3, s3c, mix, z, w;
        logic flag;
        t_out_item o;
        one = 64'sd65536;
        flag = 1'b0;
        a[0] = 64'(it.in_a0); a[1] = 64'(it.in_a1); a[2] = 64'(it.in_a2);
        a[3] = 64'(it.in_a3); a[4] = 64'(it.in_a4); a[5] = 64'(it.in_a5);
        for (int i = 0; i < 6; i++) r[i] = '0;
        c = angle_reg[REG_COS_T];
        c2 = angle_reg[REG_COS_2T];
        c4t = angle_reg[REG_COS_4T];
        sp = angle_reg[REG_SIN_T];
        s = it.rotate_out ? -angle_reg[REG_SIN_T] : angle_reg[REG_SIN_T];
        s2 = it.rotate_out ? -angle_reg[REG_SIN_2T] : angle_reg[REG_SIN_2T];
        s4t = it.rotate_out ? -angle_reg[REG_SIN_4T] : angle_reg[REG_SIN_4T];
        case (it.action)
            ACT_STRESS: begin
                p = a[0] + a[1];
                d = a[0] - a[1];
                r[0] = rnd_shift(p * one + d * c2 + 2 * a[2] * s2, 17);
                r[1] = rnd_shift(p * one - d * c2 - 2 * a[2] * s2, 17);
                r[2] = rnd_shift(2 * a[2] * c2 - d * s2, 17);
            end
            ACT_TENSOR: begin
                cc = rnd_shift(c * c, 16);
                ss = rnd_shift(s * s, 16);
                sc = rnd_shift(s * c, 16);
                c4 = rnd_shift(cc * cc, 16);
                s4 = rnd_shift(ss * ss, 16);
                s2c2 = rnd_shift(ss * cc, 16);
                sc3 = rnd_shift(sc * cc, 16);
                s3c = rnd_shift(sc * ss, 16);
                mix = s2c2 * (2 * a[1] + 4 * a[5]);
                z = (a[0] + a[3]) * one - c4t * (a[0] + a[3]) + 2 * c4t * a[1]
                    + 4 * c4t * a[5] + 4 * s4t * (a[2] - a[4]);
                w = 2 * s2 * (a[0] - a[3]) + 4 * c2 * (a[2] + a[4]);
                r[0] = rnd_shift(c4 * a[0] + s4 * a[3] + mix - 4 * sc3 * a[2]
                                 - 4 * s3c * a[4], 16);
                r[1] = rnd_shift((6 * a[1] - 4 * a[5]) * one + z, 19);
                r[2] = rnd_shift(w - 4 * c4t * a[4] + 4 * c4t * a[2]
                                 + s4t * (a[0] + a[3] - 2 * a[1] - 4 * a[5]), 19);
                r[3] = rnd_shift(s4 * a[0] + c4 * a[3] + mix + 4 * sc3 * a[4]
                                 + 4 * s3c * a[2], 16);
                r[4] = rnd_shift(w + 4 * c4t * a[4] - 4 * c4t * a[2]
                                 - s4t * (a[0] + a[3] - 2 * a[1] - 4 * a[5]), 19);
                r[5] = rnd_shift((4 * a[5] - 2 * a[1]) * one + z, 19);
            end
            ACT_MATRIX: begin
                // always the positive angle
                if (it.index_sel) begin
                    r[0] = rnd_shift(a[0] * c + a[1] * sp, 16);
                    r[1] = rnd_shift(a[1] * c - a[0] * sp, 16);
                    r[2] = rnd_shift(a[2] * c + a[3] * sp, 16);
                    r[3] = rnd_shift(a[3] * c - a[2] * sp, 16);
                end else begin
                    r[0] = rnd_shift(c * a[0] + sp * a[2], 16);
                    r[1] = rnd_shift(c * a[1] + sp * a[3], 16);
                    r[2] = rnd_shift(c * a[2] - sp * a[0], 16);
                    r[3] = rnd_shift(c * a[3] - sp * a[1], 16);
                end
            end
            default: ;
        endcase
        o.out_b0 = sat_word(r[0], flag);
        o.out_b1 = sat_word(r[1], flag);
        o.out_b2 = sat_word(r[2], flag);
        o.out_b3 = sat_word(r[3], flag);
        o.out_b4 = sat_word(r[4], flag);
        o.out_b5 = sat_word(r[5], flag);
        o.saturated = flag;
        return o;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return t_word'($urandom_range(0, 131072)) - 65536;
            3: return t_word'($signed($urandom) >>> $urandom_range(4, 20));
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_item(t_action act);
        t_in_item it;
        it.action = act;
        it.rotate_out = 1'($urandom_range(0, 1));
        it.index_sel = 1'($urandom_range(0, 1));
        it.in_a0 = rand_word(); it.in_a1 = rand_word(); it.in_a2 = rand_word();
        it.in_a3 = rand_word(); it.in_a4 = rand_word(); it.in_a5 = rand_word();
        return it;
    endfunction

    // Driver: one beat per accepted start, random gaps
    always @(posedge i_clk) begin
        if (start && !busy) begin
            rotated_q.push_back(rotate_item(i_item));
        end
        if (start && busy) begin
            // hold the beat
        end else if (drive_en && pending_items.size() > 0 && gap_left == 0) begin
            start <= 1'b1;
            i_item <= pending_items.pop_front();
            case ($urandom_range(0, 9))
                0, 1, 2: gap_left <= $urandom_range(1, 3);
                3: gap_left <= $urandom_range(5, 30);
                default: gap_left <= 0;
            endcase
        end else begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_done) begin
            if (rotated_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("Unexpected result %h", o_result);
            end else begin
                exp_r = rotated_q.pop_front();
                if (o_result !== exp_r) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Result mismatch: expected %h actual %h", exp_r, o_result);
                end
            end
        end
    end

    task automatic write_angle(logic [IDX_W-1:0] idx, logic [TRIG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        angle_reg[idx] = 64'($signed(val));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Run queued beats and wait until all results are in
    task automatic run_batch();
        drive_en = 1'b1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        @(posedge i_clk);
        drive_en = 1'b0;
        wait (rotated_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_angle(int ct, int st, int c2t, int s2t, int c4t, int s4t);
        write_angle(REG_COS_T, ct[TRIG_W-1:0]);
        write_angle(REG_SIN_T, st[TRIG_W-1:0]);
        write_angle(REG_COS_2T, c2t[TRIG_W-1:0]);
        write_angle(REG_SIN_2T, s2t[TRIG_W-1:0]);
        write_angle(REG_COS_4T, c4t[TRIG_W-1:0]);
        write_angle(REG_SIN_4T, s4t[TRIG_W-1:0]);
    endtask

    initial begin
        t_in_item it;
        angle_reg[0] = 64'sd65536; angle_reg[1] = 64'sd0; angle_reg[2] = 64'sd65536;
        angle_reg[3] = 64'sd0; angle_reg[4] = 64'sd65536; angle_reg[5] = 64'sd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity angle, every action, both directions, extremes
        for (int k = 0; k < 16; k++) begin
            it = make_item(t_action'(k % 4));
            it.rotate_out = k[2];
            it.index_sel = k[3];
            if (k < 4) begin
                it.in_a0 = 32'h7fffffff; it.in_a1 = 32'h80000000;
                it.in_a2 = 32'h7fffffff; it.in_a3 = 32'h80000000;
                it.in_a4 = 32'h7fffffff; it.in_a5 = 32'h80000000;
            end else if (k < 8) begin
                it.in_a0 = '0; it.in_a1 = '0; it.in_a2 = '0;
                it.in_a3 = '0; it.in_a4 = '0; it.in_a5 = '0;
            end
            pending_items.push_back(it);
        end
        run_batch();

        // 30 degrees, then values of magnitude one, then raw corners of the register range
        set_angle(56756, 32768, 32768, 56756, -32768, 56756);
        for (int k = 0; k < 8; k++) pending_items.push_back(make_item(t_action'(k % 4)));
        run_batch();
        set_angle(-65536, 65536, -65536, 65536, -65536, 65536);
        for (int k = 0; k < 8; k++) pending_items.push_back(make_item(t_action'(k % 4)));
        run_batch();
        set_angle(131071, -131072, 131071, -131072, 131071, -131072);
        for (int k = 0; k < 8; k++) pending_items.push_back(make_item(t_action'(k % 4)));
        run_batch();

        // Random phases with random angles, the last one at the identity angle
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) set_angle(65536, 0, 65536, 0, 65536, 0);
            else
                set_angle($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                          $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                          $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536);
            for (int k = 0; k < 100; k++)
                pending_items.push_back(make_item(t_action'($urandom_range(0, 3))));
            run_batch();
        end

        if (mismatch_cnt == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
